// File: rtl/core/tecf_pkg.sv
// Shared constants and types for the track edge centerline finder.
package tecf_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int WIDTH_CAP = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    localparam int COL_W = 10;
    localparam int ROW_W = 10;
    localparam int CFG_W = 11;
    localparam int PIX_W = 8;

    localparam logic [CFG_W-1:0] WIDTH_MIN = CFG_W'(2);
    localparam logic [CFG_W-1:0] WIDTH_MAX = CFG_W'(WIDTH_CAP);

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = CFG_W'(640);
    localparam logic [ROW_W-1:0] FIRST_ROW_RESET = ROW_W'(160);

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH = 1'b0;
    localparam logic CFG_FIRST_ROW = 1'b1;

    typedef struct packed {
        logic             right_found;
        logic             left_found;
        logic [COL_W-1:0] center_line;
        logic [COL_W-1:0] right_edge;
        logic [COL_W-1:0] left_edge;
        logic [ROW_W-1:0] row_index;
    } scan_result_t;

endpackage

// File: rtl/core/tecf_row_scan.sv
// Per-row edge search state: column and row counters, held edges and found flags.
module tecf_row_scan
    import tecf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [PIX_W-1:0] pix,
    input  logic             start,
    input  logic [CFG_W-1:0] width,
    input  logic [ROW_W-1:0] first_row,
    output scan_result_t     res,
    output logic             res_valid
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] left_reg, left_next;
    logic [COL_W-1:0] right_reg, right_next;
    logic             lseen_reg, lseen_next;
    logic             rseen_reg, rseen_next;

    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] centre;
    logic [COL_W:0]   edge_sum;
    logic             active;
    logic             black;
    logic             last;
    logic             lseen_cur;
    logic             rseen_cur;

    always_comb
    begin
        // A frame start clears everything before this pixel is looked at.
        x          = start ? '0 : col_reg;
        row        = start ? '0 : row_reg;
        left_next  = start ? '0 : left_reg;
        right_next = start ? '0 : right_reg;
        lseen_cur  = start ? 1'b0 : lseen_reg;
        rseen_cur  = start ? 1'b0 : rseen_reg;

        centre = COL_W'(width >> 1);
        active = row >= first_row;
        black  = pix == '0;
        last   = {1'b0, x} >= (width - CFG_W'(1));

        if (active && black && x >= centre && !rseen_cur)
        begin
            right_next = x;
            rseen_cur  = 1'b1;
        end
        if (active && black && x <= centre)
        begin
            left_next = x;
            lseen_cur = 1'b1;
        end

        edge_sum = {1'b0, left_next} + {1'b0, right_next};

        res.row_index   = row;
        res.left_edge   = left_next;
        res.right_edge  = right_next;
        res.center_line = edge_sum[COL_W:1];
        res.left_found  = lseen_cur;
        res.right_found = rseen_cur;
        res_valid       = last && active;

        if (last)
        begin
            col_next   = '0;
            row_next   = row + ROW_W'(1);
            lseen_next = 1'b0;
            rseen_next = 1'b0;
        end
        else
        begin
            col_next   = x + COL_W'(1);
            row_next   = row;
            lseen_next = lseen_cur;
            rseen_next = rseen_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            lseen_reg <= 1'b0;
            rseen_reg <= 1'b0;
        end
        else if (step)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            lseen_reg <= lseen_next;
            rseen_reg <= rseen_next;
        end
    end

endmodule

// File: rtl/core/track_edge_centerline_finder.sv
// Top level of the track edge centerline finder.
//
// Pixels of a thresholded frame arrive in raster order on the s_ channel,
// one item per pixel; s_tuser marks the first pixel of a frame. From the
// configured first row onward, each row yields one item on the m_ channel at
// its last pixel, carrying the row number, the left and right edge columns,
// their floored midpoint and the two found flags. Other pixels give no item.
//
// Throughput is one pixel per clock while m_tready is high. A pixel is
// captured in an input register and handled by the row scan logic when the
// output slot is free or emptying; its result item is registered onto m_.
// The output register and the input register form a two-deep pipeline, so a
// new pixel is taken while a result waits; when m_tready stays low the
// pipeline fills and s_tready drops until the result is taken.
//
// The cfg channel is always ready and writes image_width (index 0) or
// first_row (index 1); it is meant to be used while the stream is idle.
// Reset sets image_width to 640, first_row to 160 and clears all counters,
// held edges and pending items.
module track_edge_centerline_finder
    import tecf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // pixel_value
    input  logic             s_tuser,   // frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    // row_index, left_edge, right_edge, center_line, left_found, right_found, zero fill
    output logic [47:0]      m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] width_cfg_reg;
    logic [ROW_W-1:0] first_row_reg;
    logic [CFG_W-1:0] width_eff;

    logic             in_valid_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             start_reg;

    logic             out_valid_reg;
    scan_result_t     out_reg;

    logic             advance;
    logic             step;
    scan_result_t     res;
    logic             res_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= IMAGE_WIDTH_RESET;
            first_row_reg <= FIRST_ROW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: width_cfg_reg <= cfg_data;
                CFG_FIRST_ROW:   first_row_reg <= cfg_data[ROW_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (width_cfg_reg < WIDTH_MIN)
            width_eff = WIDTH_MIN;
        else if (width_cfg_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_cfg_reg;
    end

    // The scan stage may move on whenever the output slot is free or being emptied.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pix_reg   <= s_tdata;
            start_reg <= s_tuser;
        end
        if (step && res_valid)
            out_reg <= res;
    end

    tecf_row_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pix       (pix_reg),
        .start     (start_reg),
        .width     (width_eff),
        .first_row (first_row_reg),
        .res       (res),
        .res_valid (res_valid)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg};

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the track edge centerline finder.
`timescale 1ns / 100ps

module testbench
    import tecf_pkg::*;
();

    typedef enum int {ALL_WHITE, LEFT_ONLY, RIGHT_ONLY, SPARSE, DENSE} row_style_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             sof;
        logic             has_want;
        scan_result_t     want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // pixel_value
    logic               s_tuser;   // frame_start
    logic               m_tvalid;
    logic               m_tready;
    // row_index, left_edge, right_edge, center_line, left_found, right_found, zero fill
    logic [47:0]        m_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // Register copies and row scan state of the predictor.
    logic [CFG_W-1:0]   reg_width;
    logic [ROW_W-1:0]   reg_first_row;
    logic [COL_W-1:0]   col_cnt;
    logic [ROW_W-1:0]   row_cnt;
    logic [COL_W-1:0]   left_hold;
    logic [COL_W-1:0]   right_hold;
    logic               left_seen;
    logic               right_seen;

    scan_result_t       row_reports[$];
    int                 mismatch_count = 0;
    int                 pixels_sent = 0;
    int                 burst_left = 0;
    logic               gaps_on = 1'b1;
    logic               hold_request = 1'b0;
    stim_row_t          pixel_table[24];

    track_edge_centerline_finder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned active_width();
        int unsigned w;
        w = reg_width;
        if (w < WIDTH_MIN)
            w = WIDTH_MIN;
        if (w > WIDTH_MAX)
            w = WIDTH_MAX;
        return w;
    endfunction

    // Advances the row scan by one pixel; returns 1 when the pixel closes a reported row.
    function automatic logic scan_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                                        output scan_result_t rep);
        int unsigned w;
        int unsigned ctr;
        int unsigned x;
        int unsigned sum;
        logic        active;
        w = active_width();
        ctr = w >> 1;
        rep = '0;
        if (sof)
        begin
            col_cnt = '0;
            row_cnt = '0;
            left_hold = '0;
            right_hold = '0;
            left_seen = 1'b0;
            right_seen = 1'b0;
        end
        x = col_cnt;
        active = (row_cnt >= reg_first_row);
        if (active && pix == '0)
        begin
            // The right edge is the first black pixel from the centre, the left
            // edge the last one up to the centre.
            if (x >= ctr && !right_seen)
            begin
                right_hold = COL_W'(x);
                right_seen = 1'b1;
            end
            if (x <= ctr)
            begin
                left_hold = COL_W'(x);
                left_seen = 1'b1;
            end
        end
        if (x >= w - 1)
        begin
            sum = left_hold + right_hold;
            rep.row_index = row_cnt;
            rep.left_edge = left_hold;
            rep.right_edge = right_hold;
            rep.center_line = COL_W'(sum >> 1);
            rep.left_found = left_seen;
            rep.right_found = right_seen;
            left_seen = 1'b0;
            right_seen = 1'b0;
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
            return active;
        end
        col_cnt = COL_W'(x + 1);
        return 1'b0;
    endfunction

    function automatic scan_result_t row_report(input int row, input int l, input int r,
                                                input int c, input logic lf, input logic rf);
        scan_result_t rep;
        rep.row_index = ROW_W'(row);
        rep.left_edge = COL_W'(l);
        rep.right_edge = COL_W'(r);
        rep.center_line = COL_W'(c);
        rep.left_found = lf;
        rep.right_found = rf;
        return rep;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                              input logic has_want, input scan_result_t want);
        int           gap;
        scan_result_t rep;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= sof;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        pixels_sent++;
        if (scan_pixel(pix, sof, rep) && !has_want)
            row_reports.push_back(rep);
        if (has_want)
            row_reports.push_back(want);
    endtask

    // Sends whole rows at the current width, then a partial row of tail items.
    task automatic send_rows(input int rows, input logic open_frame, input int tail,
                             input logic noise);
        int          w;
        int          ctr;
        int          x;
        int          total;
        logic        black;
        logic        sof;
        row_style_t  style;
        w = active_width();
        ctr = w >> 1;
        total = rows * w + tail;
        style = ALL_WHITE;
        for (int i = 0; i < total; i++)
        begin
            x = i % w;
            if (x == 0)
                style = row_style_t'($urandom_range(0, 4));
            case (style)
                ALL_WHITE:  black = 1'b0;
                LEFT_ONLY:  black = (x <= ctr) && ($urandom_range(0, 3) == 0);
                RIGHT_ONLY: black = (x >= ctr) && ($urandom_range(0, 3) == 0);
                SPARSE:     black = ($urandom_range(0, 4) == 0);
                default:    black = ($urandom_range(0, 1) == 0);
            endcase
            // A stray frame start now and then breaks a frame in the middle.
            sof = (open_frame && i == 0) || (noise && $urandom_range(0, 599) == 0);
            send_pixel(black ? 8'd0 : 8'($urandom_range(1, 255)), sof, 1'b0, '0);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_IMAGE_WIDTH)
            reg_width = value;
        else
            reg_first_row = value[ROW_W-1:0];
    endtask

    task automatic configure(input int w, input int fr);
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(CFG_FIRST_ROW, CFG_W'(fr));
        cfg_valid <= 1'b0;
    endtask

    // Waits for every pending row report, then lets items that give no report leave the pipe.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (row_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        int rand_start;
        int pick;
        int w;
        int fr;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data = '0;
        reg_width = IMAGE_WIDTH_RESET;
        reg_first_row = FIRST_ROW_RESET;
        col_cnt = '0;
        row_cnt = '0;
        left_hold = '0;
        right_hold = '0;
        left_seen = 1'b0;
        right_seen = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register values after reset: one full-size row that is skipped, then narrow rows
        // up to one past the first row, of which the last two are reported.
        send_rows(1, 1'b1, 0, 1'b0);
        drain();
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(2));
        cfg_valid <= 1'b0;
        send_rows(int'(FIRST_ROW_RESET) + 1, 1'b0, 0, 1'b0);
        drain();

        // Directed rows at width 4, centre column 2.
        pixel_table = '{
            '{8'd255, 1'b1, 1'b0, '0},
            '{8'd0,   1'b0, 1'b0, '0},
            '{8'd0,   1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b1, row_report(0, 2, 2, 2, 1'b1, 1'b1)},
            '{8'd1,   1'b0, 1'b0, '0},
            '{8'd128, 1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b0, '0},
            '{8'd7,   1'b0, 1'b1, row_report(1, 2, 2, 2, 1'b0, 1'b0)},
            '{8'd0,   1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b0, '0},
            '{8'd0,   1'b0, 1'b1, row_report(2, 0, 3, 1, 1'b1, 1'b1)},
            '{8'd255, 1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b0, '0},
            '{8'd170, 1'b0, 1'b0, '0},
            '{8'd0,   1'b0, 1'b1, row_report(3, 0, 3, 1, 1'b0, 1'b1)},
            '{8'd255, 1'b1, 1'b0, '0},
            '{8'd0,   1'b0, 1'b0, '0},
            '{8'd85,  1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b1, row_report(0, 1, 0, 0, 1'b1, 1'b0)},
            '{8'd254, 1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b0, '0},
            '{8'd0,   1'b0, 1'b0, '0},
            '{8'd255, 1'b0, 1'b1, row_report(1, 2, 2, 2, 1'b1, 1'b1)}
        };
        configure(4, 0);
        // The receiver holds off here so the pipeline fills and the input stalls.
        hold_request = 1'b1;
        foreach (pixel_table[i])
            send_pixel(pixel_table[i].pix, pixel_table[i].sof, pixel_table[i].has_want,
                       pixel_table[i].want);
        drain();

        // Width shrinks while a row is half done, so that row ends on the next item.
        configure(16, 0);
        send_rows(1, 1'b1, 10, 1'b0);
        drain();
        configure(4, 0);
        send_rows(3, 1'b0, 0, 1'b0);
        drain();

        rand_start = pixels_sent;
        while (pixels_sent - rand_start < 420)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w = $urandom_range(0, 1);
            else if (pick < 4)
                w = $urandom_range(21, 40);
            else
                w = $urandom_range(2, 20);
            fr = $urandom_range(0, 3);
            configure(w, fr);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3))
                send_rows(fr + $urandom_range(1, 5), $urandom_range(0, 7) != 0,
                          ($urandom_range(0, 3) == 0) ?
                              $urandom_range(1, active_width() - 1) : 0,
                          1'b1);
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && row_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: stretches of random readiness, plus one long hold-off on request.
    initial
    begin
        int mode;
        int stretch;
        m_tready = 1'b0;
        mode = 0;
        stretch = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode = $urandom_range(0, 3);
                    stretch = $urandom_range(16, 200);
                end
                stretch--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        scan_result_t got;
        scan_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(scan_result_t)-1:0];
            if (row_reports.size() == 0)
            begin
                $display("%0t: item with no row report pending, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = row_reports.pop_front();
                check_field("row_index", want.row_index, got.row_index);
                check_field("left_edge", want.left_edge, got.left_edge);
                check_field("right_edge", want.right_edge, got.right_edge);
                check_field("center_line", want.center_line, got.center_line);
                check_field("left_found", want.left_found, got.left_found);
                check_field("right_found", want.right_found, got.right_found);
            end
        end
    end

endmodule

// File: sim.f
rtl/core/tecf_pkg.sv
rtl/core/tecf_row_scan.sv
rtl/core/track_edge_centerline_finder.sv
tb/testbench.sv
